// File: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, constants and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // screen geometry
  localparam int ScreenColumns = 80;
  localparam int ScreenRows    = 25;
  localparam int TabStop       = 8;

  // field widths
  localparam int GlyphW  = 8;
  localparam int ColW    = 7;
  localparam int RowW    = 5;
  localparam int ColourW = 4;
  localparam int KindW   = 2;

  // working widths: one bit of headroom for tab and wrap arithmetic
  localparam int ColWideW = ColW + 1;
  localparam int RowWideW = RowW + 1;

  // queue between the front and back parts
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // control bytes
  localparam logic [GlyphW-1:0] KeyLf  = 8'h0A;
  localparam logic [GlyphW-1:0] KeyCr  = 8'h0D;
  localparam logic [GlyphW-1:0] KeyHt  = 8'h09;
  localparam logic [GlyphW-1:0] KeyAmp = 8'h26;

  localparam logic [ColourW-1:0] TextColourReset = 4'd7;

  // result kinds
  typedef enum logic [KindW-1:0] {
    EV_CELL   = 2'd0,
    EV_SCROLL = 2'd1,
    EV_CURSOR = 2'd2
  } event_kind_t;

  // bit positions of the per-byte result mask
  localparam int MaskCell   = 0;
  localparam int MaskScroll = 1;
  localparam int MaskCursor = 2;
  localparam int MaskW      = 3;

  // everything one byte produces, carried as one queue entry
  typedef struct packed {
    logic [MaskW-1:0]   mask;
    logic [ColW-1:0]    cell_col;
    logic [RowW-1:0]    cell_row;
    logic [GlyphW-1:0]  glyph;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
    logic [ColW-1:0]    cur_col;
    logic [RowW-1:0]    cur_row;
  } bundle_t;

  // hex digit value, non-hex bytes give zero
  function automatic logic [ColourW-1:0] hex_value(input logic [GlyphW-1:0] c);
    logic [ColourW-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) v = ColourW'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = ColourW'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = ColourW'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Accepts message bytes, classifies them and updates the cursor and colour
// state; packs the results of each byte into one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tcce_pkg::ColourW-1:0]    cfg_wr_data,
  input  wire logic                            acc,
  input  wire logic [tcce_pkg::GlyphW-1:0]     glyph,
  input  wire logic                            eom,
  output tcce_pkg::bundle_t                    bundle,
  output logic                                 bundle_push
);

  localparam logic [tcce_pkg::ColWideW-1:0] TabW  = tcce_pkg::ColWideW'(tcce_pkg::TabStop);
  localparam logic [tcce_pkg::ColWideW-1:0] ColsW =
    tcce_pkg::ColWideW'(tcce_pkg::ScreenColumns);
  localparam logic [tcce_pkg::RowWideW-1:0] RowsW = tcce_pkg::RowWideW'(tcce_pkg::ScreenRows);

  logic [tcce_pkg::ColW-1:0]    cur_col_r, cur_col_nxt;
  logic [tcce_pkg::RowW-1:0]    cur_row_r, cur_row_nxt;
  logic [tcce_pkg::ColourW-1:0] colour_r, colour_nxt;
  logic                         await_r, await_nxt;
  logic [tcce_pkg::ColourW-1:0] bg_r;

  logic [tcce_pkg::ColWideW-1:0] col_a, col_b;
  logic [tcce_pkg::RowWideW-1:0] row_a, row_b;
  logic                          do_write, do_scroll;

  // byte classification and cursor update
  always_comb begin
    col_a      = {1'b0, cur_col_r};
    row_a      = {1'b0, cur_row_r};
    colour_nxt = colour_r;
    await_nxt  = await_r;
    do_write   = 1'b0;
    do_scroll  = 1'b0;

    priority if (await_r) begin
      if (glyph == tcce_pkg::KeyAmp) do_write = 1'b1;
      else colour_nxt = tcce_pkg::hex_value(glyph);
      await_nxt = 1'b0;
    end else if (glyph == tcce_pkg::KeyLf) begin
      row_a = row_a + 1'b1;
      col_a = '0;
    end else if (glyph == tcce_pkg::KeyAmp) begin
      await_nxt = 1'b1;
    end else if (glyph == tcce_pkg::KeyHt) begin
      // tab stop is a power of two, the remainder is a mask
      col_a = col_a + TabW - (col_a % TabW);
    end else if (glyph == tcce_pkg::KeyCr) begin
      col_a = '0;
    end else begin
      do_write = 1'b1;
    end

    col_b = do_write ? col_a + 1'b1 : col_a;
    row_b = row_a;

    // wrap past the right edge
    if (col_b >= ColsW) begin
      col_b = '0;
      row_b = row_b + 1'b1;
    end

    // scroll past the bottom row
    if (row_b >= RowsW) begin
      col_b     = '0;
      row_b     = RowsW - 1'b1;
      do_scroll = 1'b1;
    end

    if (eom) await_nxt = 1'b0;

    cur_col_nxt = col_b[tcce_pkg::ColW-1:0];
    cur_row_nxt = row_b[tcce_pkg::RowW-1:0];
  end

  // queue entry for this byte
  always_comb begin
    bundle.mask[tcce_pkg::MaskCell]   = do_write;
    bundle.mask[tcce_pkg::MaskScroll] = do_scroll;
    bundle.mask[tcce_pkg::MaskCursor] = eom;
    bundle.cell_col = col_a[tcce_pkg::ColW-1:0];
    bundle.cell_row = row_a[tcce_pkg::RowW-1:0];
    bundle.glyph    = glyph;
    bundle.fg       = colour_r;
    bundle.bg       = bg_r;
    bundle.cur_col  = cur_col_nxt;
    bundle.cur_row  = cur_row_nxt;
    bundle_push     = acc && (do_write || do_scroll || eom);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      colour_r  <= tcce_pkg::TextColourReset;
      await_r   <= 1'b0;
      bg_r      <= '0;
    end else begin
      if (acc) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        colour_r  <= colour_nxt;
        await_r   <= await_nxt;
      end
      if (cfg_wr_en) bg_r <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// Short queue of per-byte result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire tcce_pkg::bundle_t wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output tcce_pkg::bundle_t      rd_data,
  output logic                   valid
);

  tcce_pkg::bundle_t                mem_r [tcce_pkg::QueueDepth];
  logic [tcce_pkg::QPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [tcce_pkg::QCntW-1:0]       count_r, count_nxt;
  logic                             do_wr, do_rd;

  assign full    = (count_r == tcce_pkg::QCntW'(tcce_pkg::QueueDepth));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (!do_wr && do_rd) count_nxt = count_r - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// File: rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Takes queue entries and hands out their results one per transaction,
// cell write first, then scroll, then cursor position.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tcce_pkg::bundle_t               q_data,
  input  wire logic                            q_valid,
  output logic                                 q_rd,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [tcce_pkg::KindW-1:0]           out_event_kind,
  output logic [tcce_pkg::ColW-1:0]            out_column,
  output logic [tcce_pkg::RowW-1:0]            out_row,
  output logic [tcce_pkg::GlyphW-1:0]          out_glyph_out,
  output logic [tcce_pkg::ColourW-1:0]         out_foreground,
  output logic [tcce_pkg::ColourW-1:0]         out_background,
  output logic                                 out_last_of_run
);

  tcce_pkg::bundle_t          work_r;
  logic [tcce_pkg::MaskW-1:0] mask_r, mask_nxt, mask_left;
  logic                       take, load;

  // remaining results after the current one
  assign mask_left = mask_r & (mask_r - 1'b1);
  assign empty     = (mask_r == '0);
  assign take      = pop && !empty;
  assign load      = empty || (take && (mask_left == '0));
  assign q_rd      = load && q_valid;

  always_comb begin
    mask_nxt = mask_r;
    if (load) mask_nxt = q_valid ? q_data.mask : '0;
    else if (take) mask_nxt = mask_left;
  end

  // result fields of the lowest pending kind
  always_comb begin
    out_last_of_run = (mask_left == '0);
    out_event_kind  = tcce_pkg::EV_CURSOR;
    out_column      = work_r.cur_col;
    out_row         = work_r.cur_row;
    out_glyph_out   = '0;
    out_foreground  = '0;
    out_background  = '0;
    if (mask_r[tcce_pkg::MaskCell]) begin
      out_event_kind = tcce_pkg::EV_CELL;
      out_column     = work_r.cell_col;
      out_row        = work_r.cell_row;
      out_glyph_out  = work_r.glyph;
      out_foreground = work_r.fg;
      out_background = work_r.bg;
    end else if (mask_r[tcce_pkg::MaskScroll]) begin
      out_event_kind = tcce_pkg::EV_SCROLL;
      out_column     = '0;
      out_row        = '0;
    end
  end

  // pending mask
  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else mask_r <= mask_nxt;
  end

  // working entry
  always_ff @(posedge clk) begin
    if (q_rd) work_r <= q_data;
  end

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode console cursor engine: turns message bytes into cell writes,
// scroll events and cursor position reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: bytes with an end-of-message flag, taken when push is
//   high and full is low. Each byte is classified at once, so one byte per
//   cycle is taken while the internal queue has room.
//   Result channel: a queue interface; the oldest result sits on the out_
//   ports while empty is low and leaves when pop is high.
//   A byte gives zero to three results; the last one has out_last_of_run.
//   Path: the first result of a byte is written into the queue, then loaded
//   into the result stage, and then shows on the out_ ports.
//   Throughput: one byte per cycle in while the queue has room, one result
//   per cycle out while pop is high; the output side sets the sustained rate
//   when bytes give more than one result each. Queue depth is four byte entries.
//   Stall: when pop stays low the current result holds, the queue fills
//   and full rises until results drain.
//   Configuration: cfg_wr_en writes the background colour at the edge.
//   Reset (synchronous, rst_n low): cursor at 0,0, foreground 7,
//   background 0, queue and result stage empty.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tcce_pkg::ColourW-1:0]    cfg_wr_data,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [tcce_pkg::GlyphW-1:0]     in_glyph_in,
  input  wire logic                            in_end_of_message,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [tcce_pkg::KindW-1:0]           out_event_kind,
  output logic [tcce_pkg::ColW-1:0]            out_column,
  output logic [tcce_pkg::RowW-1:0]            out_row,
  output logic [tcce_pkg::GlyphW-1:0]          out_glyph_out,
  output logic [tcce_pkg::ColourW-1:0]         out_foreground,
  output logic [tcce_pkg::ColourW-1:0]         out_background,
  output logic                                 out_last_of_run
);

  tcce_pkg::bundle_t fr_bundle, q_data;
  logic              fr_push, q_full, q_valid, q_rd, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  // front: classify and update cursor state
  tcce_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .glyph       (in_glyph_in),
    .eom         (in_end_of_message),
    .bundle      (fr_bundle),
    .bundle_push (fr_push)
  );

  // decoupling queue
  tcce_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_push),
    .wr_data (fr_bundle),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  // back: serialize results
  tcce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_valid         (q_valid),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_event_kind  (out_event_kind),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_glyph_out   (out_glyph_out),
    .out_foreground  (out_foreground),
    .out_background  (out_background),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/tcce_checker.sv
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console cursor engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [tcce_pkg::KindW-1:0]      out_event_kind,
  input wire logic [tcce_pkg::ColW-1:0]       out_column,
  input wire logic [tcce_pkg::RowW-1:0]       out_row,
  input wire logic [tcce_pkg::GlyphW-1:0]     out_glyph_out
);

  // result side is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // results never carry an undefined kind
  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_event_kind == tcce_pkg::EV_CELL ||
                out_event_kind == tcce_pkg::EV_SCROLL ||
                out_event_kind == tcce_pkg::EV_CURSOR))
    else $error("undefined result kind");

  // positions stay on the screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_row < tcce_pkg::RowW'(tcce_pkg::ScreenRows) &&
                out_column < tcce_pkg::ColW'(tcce_pkg::ScreenColumns)))
    else $error("position off screen");

  // scroll results carry zero position and glyph
  a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_kind == tcce_pkg::EV_SCROLL) |->
      (out_column == '0 && out_row == '0 && out_glyph_out == '0))
    else $error("scroll result with nonzero fields");

  // a waiting result holds while not taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_event_kind) &&
                          $stable(out_column) && $stable(out_row)))
    else $error("waiting result changed");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .empty          (empty),
  .pop            (pop),
  .out_event_kind (out_event_kind),
  .out_column     (out_column),
  .out_row        (out_row),
  .out_glyph_out  (out_glyph_out)
);

`default_nettype wire
